[rtl/rws_pkg.sv]
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types, constants and helpers of the rolling window statistics block.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int DEV_BITS    = SAMPLE_BITS - 1;
  localparam int LEN_BITS    = 9;
  localparam int N_BITS      = 9;
  localparam int SUM_BITS    = 33;
  localparam int SQ_BITS     = 55;
  localparam int MUL_BITS    = 33;
  localparam int UNIT_BITS   = 64;
  localparam int ITER_BITS   = 7;

  localparam logic [LEN_BITS-1:0] WINDOW_RESET = LEN_BITS'(20);
  localparam logic [20:0] SQRT252_Q16 = 21'd1040352;

  // iteration counts of the shared unit for each operation
  localparam logic [ITER_BITS-1:0] ITERS_ROOT   = ITER_BITS'(32);
  localparam logic [ITER_BITS-1:0] ITERS_DEV    = ITER_BITS'(32);
  localparam logic [ITER_BITS-1:0] ITERS_MEAN   = ITER_BITS'(34);
  localparam logic [ITER_BITS-1:0] ITERS_Z      = ITER_BITS'(43);
  localparam logic [ITER_BITS-1:0] ITERS_SHARPE = ITER_BITS'(46);

  localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [DEV_BITS-1:0]    DEV_MAX = {DEV_BITS{1'b1}};

  localparam int APB_ADDR_BITS = 3;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_LENGTH = '0;

  typedef struct packed {
    logic                 start;
    logic                 sqrt_mode;
    logic [ITER_BITS-1:0] iters;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // signed saturation of a sign and magnitude pair
  function automatic logic [SAMPLE_BITS-1:0] sat_q(input logic neg,
                                                   input logic [UNIT_BITS-1:0] mag);
    logic [UNIT_BITS-1:0] lim;
    lim = UNIT_BITS'(POS_MAX);
    if (!neg) begin
      return (mag > lim) ? POS_MAX : mag[SAMPLE_BITS-1:0];
    end
    return (mag > lim + UNIT_BITS'(1)) ? NEG_MIN : (~mag[SAMPLE_BITS-1:0] + 1'b1);
  endfunction

endpackage

[rtl/rws_if.sv]
// ----------------------------------------------------------------------------
// rws_if
// Valid/ready channels of the rolling window statistics block.
// ----------------------------------------------------------------------------
interface rws_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rws_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink (input valid, sample, series_start, output ready);
endinterface

interface rws_stats_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rws_pkg::SAMPLE_BITS-1:0] window_mean;
  logic        [rws_pkg::DEV_BITS-1:0]    window_deviation;
  logic signed [rws_pkg::SAMPLE_BITS-1:0] z_score;
  logic signed [rws_pkg::SAMPLE_BITS-1:0] annual_sharpe;

  modport source (output valid, window_mean, window_deviation, z_score, annual_sharpe,
                  input ready);
  modport sink (input valid, window_mean, window_deviation, z_score, annual_sharpe,
                output ready);
endinterface

[rtl/rws_ram.sv]
// ----------------------------------------------------------------------------
// rws_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rws_mul.sv]
// ----------------------------------------------------------------------------
// rws_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rws_mul (
  input  logic                           clk,
  input  logic [rws_pkg::MUL_BITS-1:0]   a,
  input  logic [rws_pkg::MUL_BITS-1:0]   b,
  output logic [2*rws_pkg::MUL_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[rtl/rws_divsqrt.sv]
// ----------------------------------------------------------------------------
// rws_divsqrt
// Iterative restoring divider and square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rws_divsqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  rws_pkg::unit_req_t              req,
  input  logic [rws_pkg::UNIT_BITS-1:0]   a,
  input  logic [rws_pkg::UNIT_BITS-1:0]   b,
  output rws_pkg::unit_stat_t             stat,
  output logic [rws_pkg::UNIT_BITS-1:0]   result
);

  localparam int UB = rws_pkg::UNIT_BITS;
  localparam int IB = rws_pkg::ITER_BITS;

  logic          busy;
  logic          done;
  logic          sqrt_mode;
  logic [IB-1:0] cnt;
  logic [UB-1:0] rem;
  logic [UB-1:0] src;
  logic [UB-1:0] res;
  logic [UB-1:0] dsr;
  logic [UB+1:0] lhs;
  logic [UB+1:0] rhs;
  logic [UB+1:0] diff;
  logic          ge;

  // one shared compare and subtract for both operations
  always_comb begin
    if (sqrt_mode) begin
      lhs = {rem, src[UB-1:UB-2]};
      rhs = {res, 2'b01};
    end else begin
      lhs = {1'b0, rem, src[UB-1]};
      rhs = {2'b00, dsr};
    end
    diff = lhs - rhs;
    ge   = (lhs >= rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        sqrt_mode <= req.sqrt_mode;
        cnt       <= req.iters;
        rem       <= '0;
        res       <= '0;
        dsr       <= b;
        src       <= req.sqrt_mode ? a : (a << (IB'(UB) - req.iters));
      end else if (busy) begin
        rem <= ge ? diff[UB-1:0] : lhs[UB-1:0];
        res <= {res[UB-2:0], ge};
        src <= sqrt_mode ? (src << 2) : (src << 1);
        cnt <= cnt - 1'b1;
        if (cnt == IB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = res;

`ifndef SYNTHESIS
  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("unit started while busy");
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a finished run");
`endif

endmodule

[rtl/rolling_window_statistics.sv]
// ----------------------------------------------------------------------------
// rolling_window_statistics
// Rolling mean, deviation, z-score and annualised Sharpe figure of a sample
// stream over the most recent window_length samples.
// ----------------------------------------------------------------------------
// samples carries one Q8.16 sample per request; series_start clears the held
// history before the sample enters. stats returns one result per request:
// mean, population deviation, z-score and Sharpe figure, all saturated.
// window_length sits at APB byte address 0 and is to be written while idle;
// the block itself does not enforce this. Reset sets it to 20 and leaves an
// empty series. With two or more samples held the square root and four
// divisions run one after another through the one divide/root unit, each
// with a start and a wait state, among multiplies and bookkeeping. A zero
// deviation skips the last two divisions. Each sample dropped after the
// window shrinks passes once more through the check, read and drop states.
// With fewer than two samples held the sample itself is the mean, the other
// figures are zero and the unit is not used. samples.ready is high only
// while the sequencer is idle. A finished result waits in the output
// register while stats stalls; the next sample is taken meanwhile, and its
// result waits until the register frees.
// ----------------------------------------------------------------------------
module rolling_window_statistics #(
  parameter int MAX_WINDOW = rws_pkg::MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst,
  rws_sample_if.sink                          samples,
  rws_stats_if.source                         stats,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rws_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int SB = rws_pkg::SAMPLE_BITS;
  localparam int DB = rws_pkg::DEV_BITS;
  localparam int NB = rws_pkg::N_BITS;
  localparam int UB = rws_pkg::UNIT_BITS;
  localparam int MB = rws_pkg::MUL_BITS;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CHK  = 5'd1;
  localparam logic [4:0] ST_RD   = 5'd2;
  localparam logic [4:0] ST_DROP = 5'd3;
  localparam logic [4:0] ST_WR   = 5'd4;
  localparam logic [4:0] ST_ADDQ = 5'd5;
  localparam logic [4:0] ST_MQL  = 5'd6;
  localparam logic [4:0] ST_MQH  = 5'd7;
  localparam logic [4:0] ST_MSS  = 5'd8;
  localparam logic [4:0] ST_DIF  = 5'd9;
  localparam logic [4:0] ST_SQS  = 5'd10;
  localparam logic [4:0] ST_SQW  = 5'd11;
  localparam logic [4:0] ST_DVS  = 5'd12;
  localparam logic [4:0] ST_DVW  = 5'd13;
  localparam logic [4:0] ST_MNS  = 5'd14;
  localparam logic [4:0] ST_MNW  = 5'd15;
  localparam logic [4:0] ST_ZS   = 5'd16;
  localparam logic [4:0] ST_ZW   = 5'd17;
  localparam logic [4:0] ST_SHM  = 5'd18;
  localparam logic [4:0] ST_SHS  = 5'd19;
  localparam logic [4:0] ST_SHW  = 5'd20;
  localparam logic [4:0] ST_OUT  = 5'd21;

  logic [4:0]                       state;
  logic [rws_pkg::LEN_BITS-1:0]     window_length;
  logic signed [SB-1:0]             x;
  logic [AW-1:0]                    slot;
  logic [CW-1:0]                    held;
  logic signed [rws_pkg::SUM_BITS-1:0] sum;
  logic [rws_pkg::SQ_BITS-1:0]      sq;
  logic [UB-1:0]                    nq;
  logic [UB-1:0]                    d;
  logic [31:0]                      root;
  logic [DB-1:0]                    dev;
  logic signed [SB-1:0]             mean;
  logic signed [SB-1:0]             z;
  logic signed [SB-1:0]             sharpe;
  logic                             oval;
  logic signed [SB-1:0]             o_mean;
  logic [DB-1:0]                    o_dev;
  logic signed [SB-1:0]             o_z;
  logic signed [SB-1:0]             o_sharpe;

  logic [CW-1:0]                    w_eff;
  logic [NB-1:0]                    n;
  logic [AW-1:0]                    old_slot;
  logic [CW:0]                      old_wide;
  logic [SB-1:0]                    ram_rdata;
  logic signed [SB:0]               ov_s;
  logic [SB-1:0]                    ov_mag;
  logic signed [SB:0]               x_s;
  logic [SB-1:0]                    x_mag;
  logic [rws_pkg::SUM_BITS-1:0]     smag;
  logic signed [SB:0]               diff;
  logic [SB:0]                      diff_mag;
  logic [SB-1:0]                    mean_mag;
  logic [MB-1:0]                    mul_a;
  logic [MB-1:0]                    mul_b;
  logic [2*MB-1:0]                  prod;
  rws_pkg::unit_req_t               ureq;
  rws_pkg::unit_stat_t              ustat;
  logic [UB-1:0]                    ua;
  logic [UB-1:0]                    ub;
  logic [UB-1:0]                    ures;
  logic                             cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rws_pkg::ADDR_WINDOW_LENGTH[2]);
  assign prdata = (paddr[2] == rws_pkg::ADDR_WINDOW_LENGTH[2]) ? 32'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rws_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      window_length <= pwdata[rws_pkg::LEN_BITS-1:0];
    end
  end

  always_comb begin
    if (window_length == '0) begin
      w_eff = CW'(1);
    end else if (window_length > rws_pkg::LEN_BITS'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(window_length);
    end
  end

  // oldest held entry
  always_comb begin
    old_wide = (CW+1)'(slot) + (CW+1)'(MAX_WINDOW) - (CW+1)'(held);
    if (old_wide >= (CW+1)'(MAX_WINDOW)) begin
      old_wide = old_wide - (CW+1)'(MAX_WINDOW);
    end
    old_slot = AW'(old_wide);
  end

  assign n        = NB'(held);
  assign ov_s     = (SB+1)'($signed(ram_rdata));
  assign ov_mag   = SB'(ov_s < 0 ? -ov_s : ov_s);
  assign x_s      = (SB+1)'(x);
  assign x_mag    = SB'(x_s < 0 ? -x_s : x_s);
  assign smag     = (sum < 0) ? -sum : sum;
  assign diff     = (SB+1)'(x) - (SB+1)'(mean);
  assign diff_mag = (diff < 0) ? -diff : diff;
  assign mean_mag = (mean < 0) ? -mean : mean;

  rws_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_WR),
    .waddr (slot),
    .wdata (x),
    .raddr (old_slot),
    .rdata (ram_rdata)
  );

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_RD: begin
        mul_a = MB'(ov_mag);
        mul_b = MB'(ov_mag);
      end
      ST_WR: begin
        mul_a = MB'(x_mag);
        mul_b = MB'(x_mag);
      end
      ST_MQL: begin
        mul_a = MB'(n);
        mul_b = MB'(sq[27:0]);
      end
      ST_MQH: begin
        mul_a = MB'(n);
        mul_b = MB'(sq[rws_pkg::SQ_BITS-1:28]);
      end
      ST_MSS: begin
        mul_a = MB'(smag);
        mul_b = MB'(smag);
      end
      ST_SHM: begin
        mul_a = MB'(mean_mag);
        mul_b = MB'(rws_pkg::SQRT252_Q16);
      end
      default: begin
      end
    endcase
  end

  rws_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // divide and root requests
  always_comb begin
    ureq = '0;
    ua   = '0;
    ub   = '0;
    unique case (state)
      ST_SQS: begin
        ureq = '{start: 1'b1, sqrt_mode: 1'b1, iters: rws_pkg::ITERS_ROOT};
        ua   = d;
      end
      ST_DVS: begin
        ureq = '{start: 1'b1, sqrt_mode: 1'b0, iters: rws_pkg::ITERS_DEV};
        ua   = UB'(root);
        ub   = UB'(n);
      end
      ST_MNS: begin
        ureq = '{start: 1'b1, sqrt_mode: 1'b0, iters: rws_pkg::ITERS_MEAN};
        ua   = UB'({smag, 1'b0}) + UB'(n);
        ub   = UB'({n, 1'b0});
      end
      ST_ZS: begin
        ureq = '{start: 1'b1, sqrt_mode: 1'b0, iters: rws_pkg::ITERS_Z};
        ua   = UB'({diff_mag, 17'b0}) + UB'(dev);
        ub   = UB'({dev, 1'b0});
      end
      ST_SHS: begin
        ureq = '{start: 1'b1, sqrt_mode: 1'b0, iters: rws_pkg::ITERS_SHARPE};
        ua   = UB'({prod[43:0], 1'b0}) + UB'(dev);
        ub   = UB'({dev, 1'b0});
      end
      default: begin
      end
    endcase
  end

  rws_divsqrt u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (ureq),
    .a      (ua),
    .b      (ub),
    .stat   (ustat),
    .result (ures)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= '0;
      held  <= '0;
      sum   <= '0;
      sq    <= '0;
      oval  <= 1'b0;
    end else begin
      // in ST_OUT the load below decides the flag
      if (oval && stats.ready && state != ST_OUT) begin
        oval <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            x     <= samples.sample;
            state <= ST_CHK;
            if (samples.series_start) begin
              slot <= '0;
              held <= '0;
              sum  <= '0;
              sq   <= '0;
            end
          end
        end
        ST_CHK: begin
          state <= (held >= w_eff) ? ST_RD : ST_WR;
        end
        ST_RD: begin
          sum   <= sum - rws_pkg::SUM_BITS'(ov_s);
          state <= ST_DROP;
        end
        ST_DROP: begin
          sq    <= sq - prod[rws_pkg::SQ_BITS-1:0];
          held  <= held - 1'b1;
          state <= ST_CHK;
        end
        ST_WR: begin
          sum   <= sum + rws_pkg::SUM_BITS'(x_s);
          slot  <= (slot == AW'(MAX_WINDOW - 1)) ? '0 : slot + 1'b1;
          held  <= held + 1'b1;
          state <= ST_ADDQ;
        end
        ST_ADDQ: begin
          sq <= sq + prod[rws_pkg::SQ_BITS-1:0];
          if (held < CW'(2)) begin
            mean   <= x;
            dev    <= '0;
            z      <= '0;
            sharpe <= '0;
            state  <= ST_OUT;
          end else begin
            state <= ST_MQL;
          end
        end
        ST_MQL: begin
          state <= ST_MQH;
        end
        ST_MQH: begin
          nq    <= UB'(prod[36:0]);
          state <= ST_MSS;
        end
        ST_MSS: begin
          nq    <= nq + {prod[35:0], 28'b0};
          state <= ST_DIF;
        end
        ST_DIF: begin
          d     <= (nq > prod[UB-1:0]) ? nq - prod[UB-1:0] : '0;
          state <= ST_SQS;
        end
        ST_SQS: begin
          state <= ST_SQW;
        end
        ST_SQW: begin
          if (ustat.done) begin
            root  <= ures[31:0];
            state <= ST_DVS;
          end
        end
        ST_DVS: begin
          state <= ST_DVW;
        end
        ST_DVW: begin
          if (ustat.done) begin
            dev   <= (ures > UB'(rws_pkg::DEV_MAX)) ? rws_pkg::DEV_MAX : ures[DB-1:0];
            state <= ST_MNS;
          end
        end
        ST_MNS: begin
          state <= ST_MNW;
        end
        ST_MNW: begin
          if (ustat.done) begin
            mean <= rws_pkg::sat_q(sum < 0, ures);
            if (dev == '0) begin
              z      <= '0;
              sharpe <= '0;
              state  <= ST_OUT;
            end else begin
              state <= ST_ZS;
            end
          end
        end
        ST_ZS: begin
          state <= ST_ZW;
        end
        ST_ZW: begin
          if (ustat.done) begin
            z     <= rws_pkg::sat_q(diff < 0, ures);
            state <= ST_SHM;
          end
        end
        ST_SHM: begin
          state <= ST_SHS;
        end
        ST_SHS: begin
          state <= ST_SHW;
        end
        ST_SHW: begin
          if (ustat.done) begin
            sharpe <= rws_pkg::sat_q(mean < 0, ures);
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!oval || stats.ready) begin
            oval     <= 1'b1;
            o_mean   <= mean;
            o_dev    <= dev;
            o_z      <= z;
            o_sharpe <= sharpe;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign samples.ready          = (state == ST_IDLE);
  assign stats.valid            = oval;
  assign stats.window_mean      = o_mean;
  assign stats.window_deviation = o_dev;
  assign stats.z_score          = o_z;
  assign stats.annual_sharpe    = o_sharpe;

`ifndef SYNTHESIS
  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held <= CW'(MAX_WINDOW)) else $error("held count beyond ring depth");
  a_result_loaded : assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!oval || stats.ready)) |=> oval && state == ST_IDLE)
    else $error("result not presented");
  a_unit_wait : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQW || state == ST_DVW || state == ST_MNW || state == ST_ZW ||
     state == ST_SHW) |-> (ustat.busy || ustat.done)) else $error("waiting on idle unit");
`endif

endmodule
